// File: hdl/rbdsgf_pkg.sv
package rbdsgf_pkg;

	// Field and block widths
	localparam int unsigned BLOCK_W = 26;
	localparam int unsigned PI_W    = 16;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned CODE_W  = 5;
	localparam int unsigned NUM_W   = 15;  // offset into a call letter range
	localparam int unsigned REM_W   = 10;  // remainder after the top letter

	// PI range limits
	localparam logic [PI_W-1:0] PI_LIM_3LTR = 16'h1000;
	localparam logic [PI_W-1:0] PI_LIM_K    = 16'h54A8;
	localparam logic [PI_W-1:0] PI_LIM_W    = 16'h9950;
	localparam logic [PI_W-1:0] PI_LIM_AA   = 16'hAA00;
	localparam logic [PI_W-1:0] PI_LIM_AF   = 16'hAFB0;
	localparam logic [PI_W-1:0] PI_BASE_K   = 16'd4096;
	localparam logic [PI_W-1:0] PI_BASE_W   = 16'd21672;

	// Base-26 constants; the low reciprocal is exact over the range used, the high one needs one correction
	localparam int unsigned DIV_HI     = 676;
	localparam int unsigned DIV_LO     = 26;
	localparam int unsigned RECIP_HI   = 1551;  // floor(2^20 / 676), under by at most one
	localparam int unsigned SHIFT_HI   = 20;
	localparam int unsigned RECIP_LO   = 631;   // ceil(2^14 / 26), exact below 744
	localparam int unsigned SHIFT_LO   = 14;

	// Characters
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 7'h24;
	localparam logic [CHAR_W-1:0] CH_APOS  = 7'h27;
	localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
	localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_THREE = 7'h33;
	localparam logic [CHAR_W-1:0] CH_UPA   = 7'h41;
	localparam logic [CHAR_W-1:0] CH_UPK   = 7'h4B;
	localparam logic [CHAR_W-1:0] CH_UPL   = 7'h4C;
	localparam logic [CHAR_W-1:0] CH_UPR   = 7'h52;
	localparam logic [CHAR_W-1:0] CH_UPT   = 7'h54;
	localparam logic [CHAR_W-1:0] CH_UPW   = 7'h57;
	localparam logic [CHAR_W-1:0] CH_CARET = 7'h5E;
	localparam logic [CHAR_W-1:0] CH_GRAVE = 7'h60;
	localparam logic [CHAR_W-1:0] CH_BAR   = 7'h7C;
	localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;

	// Fields that run alongside the divider
	typedef struct packed {
		logic [CODE_W-1:0]            grp_code;
		logic                         traffic_program;
		logic [CODE_W-1:0]            program_type;
		logic [3:0][CHAR_W-1:0]       call_letter;
		logic                         is_b26;
		logic [CHAR_W-1:0]            text_char;
	} side_t;

	// Stage enables for the divider stages
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctrl_t;

	// Upper case hex digit
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return CH_ZERO + {3'b000, v};
		else
			return CH_UPA + {3'b000, v - 4'd10};
	endfunction

	// RadioText byte to printable ASCII
	function automatic logic [CHAR_W-1:0] map_text(input logic [7:0] b);
		logic [CHAR_W-1:0] c;
		c = b[CHAR_W-1:0];
		if (b < 8'd32 || b >= 8'd127)
			return CH_SPACE;
		case (c)
			CH_DOLLAR: return CH_SPACE;
			CH_COMMA:  return CH_APOS;
			CH_CARET:  return CH_DASH;
			CH_TILDE:  return CH_DASH;
			CH_GRAVE:  return CH_BAR;
			default:   return c;
		endcase
	endfunction

endpackage

// File: hdl/rbdsgf_extract.sv
module rbdsgf_extract
	import rbdsgf_pkg::*;
(
	input  logic                 clk,
	input  logic                 load,
	input  logic [79:0]          tdata,  // block_a, block_b, block_x, pad
	input  logic                 tuser,  // first_char
	output side_t                side_s1,
	output logic [NUM_W-1:0]     num_s1
);

	logic [BLOCK_W-1:0] blk_a;
	logic [BLOCK_W-1:0] blk_b;
	logic [BLOCK_W-1:0] blk_x;
	logic [PI_W-1:0]    pi;
	logic [PI_W-1:0]    pi_off;
	logic [7:0]         txt_byte;
	side_t              side_d;

	assign blk_a = tdata[25:0];
	assign blk_b = tdata[51:26];
	assign blk_x = tdata[77:52];
	assign pi    = blk_a[25:10];

	// RadioText byte select
	assign txt_byte = tuser ? blk_x[25:18] : blk_x[17:10];

	// PI range decode; base-26 letters are filled in later
	always_comb begin
		side_d.grp_code        = blk_b[25:21];
		side_d.traffic_program = blk_b[20];
		side_d.program_type    = blk_b[19:15];
		side_d.text_char       = map_text(txt_byte);
		side_d.is_b26          = 1'b0;
		pi_off                 = pi - PI_BASE_K;
		if (pi < PI_LIM_3LTR) begin
			side_d.call_letter = {CH_UPR, CH_UPT, CH_UPL, CH_THREE};
		end else if (pi < PI_LIM_K) begin
			side_d.is_b26      = 1'b1;
			side_d.call_letter = {CH_SPACE, CH_SPACE, CH_SPACE, CH_UPK};
		end else if (pi < PI_LIM_W) begin
			side_d.is_b26      = 1'b1;
			pi_off             = pi - PI_BASE_W;
			side_d.call_letter = {CH_SPACE, CH_SPACE, CH_SPACE, CH_UPW};
		end else if (pi < PI_LIM_AA) begin
			side_d.call_letter = {hex_char(pi[3:0]), hex_char(pi[7:4]), CH_ZERO,
				hex_char(pi[11:8])};
		end else if (pi < PI_LIM_AF) begin
			side_d.call_letter = {CH_ZERO, CH_ZERO, hex_char(pi[3:0]),
				hex_char(pi[7:4])};
		end else begin
			side_d.call_letter = {hex_char(pi[3:0]), hex_char(pi[7:4]),
				hex_char(pi[11:8]), hex_char(pi[15:12])};
		end
	end

	// Stage 1 register
	always_ff @(posedge clk) begin
		if (load) begin
			side_s1 <= side_d;
			num_s1  <= pi_off[NUM_W-1:0];
		end
	end

endmodule

// File: hdl/rbdsgf_base26.sv
module rbdsgf_base26
	import rbdsgf_pkg::*;
(
	input  logic                 clk,
	input  pipe_ctrl_t           ctrl,
	input  logic [NUM_W-1:0]     num_s1,
	output logic [CODE_W-1:0]    hi_s4,
	output logic [CODE_W-1:0]    mid_s4,
	output logic [REM_W-1:0]     rem_s4
);

	logic [25:0]        prod_hi;
	logic [CODE_W-1:0]  hi_est_s2;
	logic [NUM_W-1:0]   num_s2;
	logic [NUM_W-1:0]   rem_raw;
	logic [CODE_W-1:0]  hi_s3;
	logic [REM_W-1:0]   rem_s3;
	logic [18:0]        prod_lo;

	// Stage 2: estimate of num / 676 by reciprocal
	assign prod_hi = 26'(num_s1) * 26'(RECIP_HI);

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			hi_est_s2 <= prod_hi[SHIFT_HI +: CODE_W];
			num_s2    <= num_s1;
		end
	end

	// Stage 3: remainder and single correction step
	assign rem_raw = num_s2 - NUM_W'(hi_est_s2) * NUM_W'(DIV_HI);

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			if (rem_raw >= NUM_W'(DIV_HI)) begin
				hi_s3  <= hi_est_s2 + 5'd1;
				rem_s3 <= REM_W'(rem_raw - NUM_W'(DIV_HI));
			end else begin
				hi_s3  <= hi_est_s2;
				rem_s3 <= rem_raw[REM_W-1:0];
			end
		end
	end

	// Stage 4: middle letter, remainder / 26
	assign prod_lo = 19'(rem_s3) * 19'(RECIP_LO);

	always_ff @(posedge clk) begin
		if (ctrl.en_s4) begin
			hi_s4  <= hi_s3;
			mid_s4 <= prod_lo[SHIFT_LO +: CODE_W];
			rem_s4 <= rem_s3;
		end
	end

endmodule

// File: hdl/rbds_group_field_decoder_top.sv
// An accepted request passes through stage registers s1 to s5 on its way to m_tvalid.
// Throughput: one request per cycle while m_tready does not stall; a five-stage valid/ready
// pipeline, the divide by 676 and by 26 done by reciprocal multiplies in stages two and four.
// A stall on m_tready holds each occupied stage with no empty stage below it; empty stages still fill.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data is not reset.
module rbds_group_field_decoder_top
	import rbdsgf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // block_a[25:0], block_b[51:26], block_x[77:52], zero pad
	input  logic        s_tuser,  // first_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // grp_code, traffic_program, program_type,
	                              // call_letter_0..3, text_char, zero pad
);

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic               rdy_1, rdy_2, rdy_3, rdy_4, rdy_5;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [NUM_W-1:0]   num_s1;
	logic [CODE_W-1:0]  hi_s4, mid_s4, lo_d;
	logic [REM_W-1:0]   rem_s4;
	pipe_ctrl_t         ctrl;
	side_t              side_d5;

	// Ready chain: a stage loads when empty or when it passes its item on
	assign rdy_5 = !valid_s5 || m_tready;
	assign rdy_4 = !valid_s4 || rdy_5;
	assign rdy_3 = !valid_s3 || rdy_4;
	assign rdy_2 = !valid_s2 || rdy_3;
	assign rdy_1 = !valid_s1 || rdy_2;
	assign s_tready = rdy_1;

	assign ctrl.en_s2 = rdy_2;
	assign ctrl.en_s3 = rdy_3;
	assign ctrl.en_s4 = rdy_4;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_1) valid_s1 <= s_tvalid;
			if (rdy_2) valid_s2 <= valid_s1;
			if (rdy_3) valid_s3 <= valid_s2;
			if (rdy_4) valid_s4 <= valid_s3;
			if (rdy_5) valid_s5 <= valid_s4;
		end
	end

	rbdsgf_extract u_extract (
		.clk     (clk),
		.load    (rdy_1),
		.tdata   (s_tdata),
		.tuser   (s_tuser),
		.side_s1 (side_s1),
		.num_s1  (num_s1)
	);

	rbdsgf_base26 u_base26 (
		.clk    (clk),
		.ctrl   (ctrl),
		.num_s1 (num_s1),
		.hi_s4  (hi_s4),
		.mid_s4 (mid_s4),
		.rem_s4 (rem_s4)
	);

	// Side fields follow the divider
	always_ff @(posedge clk) begin
		if (rdy_2) side_s2 <= side_s1;
		if (rdy_3) side_s3 <= side_s2;
		if (rdy_4) side_s4 <= side_s3;
	end

	// Stage 5: low letter and final call letters
	assign lo_d = CODE_W'(rem_s4 - REM_W'(mid_s4 * 10'(DIV_LO)));

	always_comb begin
		side_d5 = side_s4;
		if (side_s4.is_b26) begin
			side_d5.call_letter[1] = CH_UPA + CHAR_W'(hi_s4);
			side_d5.call_letter[2] = CH_UPA + CHAR_W'(mid_s4);
			side_d5.call_letter[3] = CH_UPA + CHAR_W'(lo_d);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_5) side_s5 <= side_d5;
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = {2'b00, side_s5.text_char,
		side_s5.call_letter[3], side_s5.call_letter[2],
		side_s5.call_letter[1], side_s5.call_letter[0],
		side_s5.program_type, side_s5.traffic_program, side_s5.grp_code};

	// An empty first stage always takes a request
	a_bubble_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("empty stage 1 refused a request");

	// Downstream ready propagates to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("ready chain broken");

	// A blocked stage keeps its item
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rdy_2 |=> valid_s2 && $stable(side_s2))
		else $error("stage 2 lost an item under stall");

	// Divider results stay within letter range
	a_b26_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && side_s4.is_b26 |->
			hi_s4 <= 5'd25 && mid_s4 <= 5'd25 && rem_s4 < 10'd676)
		else $error("base-26 digit out of range");

endmodule
